### rtl/hba_pkg.sv
// Shared types, constants and helpers of the best-fit heap allocator.
package hba_pkg;

  localparam int REGION_BYTES = 4096;
  localparam int HEADER_BYTES = 9;
  localparam int ANCHOR_BYTES = 4;

  localparam int ADDR_W = 12;
  localparam int SIZE_W = 13;

  // One block header as kept in the header memory.
  typedef struct packed {
    logic              is_free;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] next;
  } hdr_t;

  // Request kinds.
  localparam logic [1:0] KIND_ALLOC  = 2'd0;
  localparam logic [1:0] KIND_FREE   = 2'd1;
  localparam logic [1:0] KIND_CHECK  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FAIL    = 2'd1;
  localparam logic [1:0] STAT_DFREE   = 2'd2;
  localparam logic [1:0] STAT_UNKNOWN = 2'd3;

  localparam logic [ADDR_W-1:0] ANCHOR_ADDR = ADDR_W'(ANCHOR_BYTES);
  localparam logic [ADDR_W-1:0] STEP_MAX    = ADDR_W'(REGION_BYTES - 1);
  localparam logic [SIZE_W-1:0] SIZE_MIN    = SIZE_W'(ANCHOR_BYTES + HEADER_BYTES + 1);
  localparam logic [SIZE_W-1:0] SIZE_MAX    = SIZE_W'(REGION_BYTES);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_WALK,
    S_AFIN,
    S_AWRITE,
    S_FNEXT,
    S_FWRITE,
    S_DONE
  } state_t;

  // Access request from the controller to the header memory.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    hdr_t              wr_data;
  } mem_req_t;

  function automatic hdr_t mk_hdr(input logic f, input logic [SIZE_W-1:0] s,
                                  input logic [ADDR_W-1:0] n);
    hdr_t h;
    h.is_free = f;
    h.size    = s;
    h.next    = n;
    return h;
  endfunction

  // Heap header for a given region size, saturated to the legal range.
  function automatic hdr_t region_hdr(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (r < SIZE_MIN) r = SIZE_MIN;
    if (r > SIZE_MAX) r = SIZE_MAX;
    return mk_hdr(1'b1, r - SIZE_W'(ANCHOR_BYTES + HEADER_BYTES), '0);
  endfunction

endpackage

### rtl/best_fit_heap_allocator.sv
// Top level of the best-fit heap allocator: controller, header memory and checks.
//
// Input channel (in_valid/in_stall) carries one request item: in_kind selects
// allocate, free or check; in_alloc_size and in_block_offset are its operands.
// Output channel (out_valid/out_stall) returns one item per request: out_status
// and out_user_offset. The configuration channel (cfg_valid/cfg_ready) writes
// the region size and rebuilds the heap as a single free block; it is taken
// only while the block is idle and no request is offered.
// Block headers live in a 4096-entry memory with a registered read port.
// A request walks the header chain one block per cycle. On a fit, allocate
// writes the chosen header as taken; when it splits a block it first writes
// the new free header and then the allocated one. Free writes one coalesced
// header, after reading the successor header when the block has one. A
// request that walks nothing goes straight to the result. One request is in
// work at a time; the next is taken the cycle after the result has moved to
// the output register, even while that register is still stalled.
// Reset (rst_n, synchronous, active low) sets a 4096-byte region and writes
// the initial header in S_INIT before the first item is taken.
// While out_stall is high a held result stays and a finished request waits behind it.
module best_fit_heap_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_kind,
  input  logic [hba_pkg::SIZE_W-1:0]   in_alloc_size,
  input  logic [hba_pkg::ADDR_W-1:0]   in_block_offset,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hba_pkg::SIZE_W-1:0]   cfg_region_size,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [hba_pkg::ADDR_W-1:0]   out_user_offset
);

  hba_pkg::mem_req_t mem_req;
  hba_pkg::hdr_t     rd_data;

  hba_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_alloc_size   (in_alloc_size),
    .in_block_offset (in_block_offset),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_region_size (cfg_region_size),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_user_offset (out_user_offset),
    .mem_req         (mem_req),
    .rd_data         (rd_data)
  );

  hba_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // The memory never reads and writes in the same cycle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_req.rd_en && mem_req.wr_en))
    else $error("header memory read and write in the same cycle");

  // A region size write rebuilds the header at the anchor.
  a_cfg_writes_anchor: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> (mem_req.wr_en && mem_req.wr_addr == hba_pkg::ANCHOR_ADDR))
    else $error("configuration write did not rebuild the heap");

  // A configuration write and a request item are never taken together.
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !cfg_ready)
    else $error("configuration and request item taken in one cycle");

  // After an item is accepted the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second item accepted while a request is in work");

endmodule

### rtl/hba_mem.sv
// Header memory: one write port and one registered read port.
module hba_mem (
  input  logic              clk,
  input  hba_pkg::mem_req_t req,
  output hba_pkg::hdr_t     rd_data
);

  hba_pkg::hdr_t mem [hba_pkg::REGION_BYTES];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

### rtl/hba_ctrl.sv
// Controller: walks the header chain and applies allocate, free and check.
module hba_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_kind,
  input  logic [hba_pkg::SIZE_W-1:0]   in_alloc_size,
  input  logic [hba_pkg::ADDR_W-1:0]   in_block_offset,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [hba_pkg::SIZE_W-1:0]   cfg_region_size,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [hba_pkg::ADDR_W-1:0]   out_user_offset,
  output hba_pkg::mem_req_t            mem_req,
  input  hba_pkg::hdr_t                rd_data
);

  hba_pkg::state_t state_r, state_nxt;
  logic [1:0]                 kind_r, kind_nxt;
  logic [hba_pkg::SIZE_W-1:0] req_r, req_nxt;
  logic [hba_pkg::ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [hba_pkg::ADDR_W-1:0] cur_r, cur_nxt;
  logic [hba_pkg::ADDR_W-1:0] steps_r, steps_nxt;
  logic                       found_r, found_nxt;
  logic [hba_pkg::ADDR_W-1:0] best_r, best_nxt;
  hba_pkg::hdr_t              best_h_r, best_h_nxt;
  logic [hba_pkg::SIZE_W-1:0] mindiff_r, mindiff_nxt;
  logic [hba_pkg::ADDR_W-1:0] prev_r, prev_nxt;
  hba_pkg::hdr_t              prev_h_r, prev_h_nxt;
  logic [hba_pkg::ADDR_W-1:0] blk_r, blk_nxt;
  hba_pkg::hdr_t              blk_h_r, blk_h_nxt;
  hba_pkg::hdr_t              hn_r, hn_nxt;
  logic                       nf_r, nf_nxt;
  logic [1:0]                 res_status_r, res_status_nxt;
  logic [hba_pkg::ADDR_W-1:0] res_off_r, res_off_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_status_r, out_status_nxt;
  logic [hba_pkg::ADDR_W-1:0] out_off_r, out_off_nxt;

  logic                       in_acc, cfg_acc, need_walk, h_last, fit, take, match;
  logic                       split, pf, out_free;
  logic [hba_pkg::SIZE_W-1:0] diff;
  logic [hba_pkg::ADDR_W-1:0] nb_addr;
  logic [hba_pkg::ADDR_W-1:0] fw_addr;
  hba_pkg::hdr_t              fw_hdr;

  // Handshake decode and per-block evaluation of the header just read.
  always_comb begin
    in_acc    = in_valid && !in_stall;
    cfg_acc   = cfg_valid && cfg_ready;
    out_free  = !out_valid_r || !out_stall;
    need_walk = (in_kind == hba_pkg::KIND_ALLOC) ? (in_alloc_size != '0)
              : ((in_kind == hba_pkg::KIND_FREE) || (in_kind == hba_pkg::KIND_CHECK));
    h_last    = (rd_data.next == '0) || (steps_r == hba_pkg::STEP_MAX);
    fit       = rd_data.is_free && (rd_data.size >= req_r);
    diff      = rd_data.size - req_r;
    take      = fit && (!found_r || (diff <= mindiff_r));
    match     = ({1'b0, cur_r} + hba_pkg::SIZE_W'(hba_pkg::HEADER_BYTES)) == {1'b0, ptr_r};
    split     = {1'b0, best_h_r.size} >= ({1'b0, req_r} + 14'(hba_pkg::HEADER_BYTES));
    nb_addr   = best_r + hba_pkg::ADDR_W'(hba_pkg::HEADER_BYTES) + req_r[hba_pkg::ADDR_W-1:0];
    pf        = (prev_r != '0) && prev_h_r.is_free;
  end

  // Coalescing result of a free.
  always_comb begin
    if (pf && nf_r) begin
      fw_addr = prev_r;
      fw_hdr  = hba_pkg::mk_hdr(1'b1, prev_h_r.size + blk_h_r.size + hn_r.size
                                + hba_pkg::SIZE_W'(2 * hba_pkg::HEADER_BYTES), hn_r.next);
    end else if (pf) begin
      fw_addr = prev_r;
      fw_hdr  = hba_pkg::mk_hdr(1'b1, prev_h_r.size + blk_h_r.size
                                + hba_pkg::SIZE_W'(hba_pkg::HEADER_BYTES), blk_h_r.next);
    end else if (nf_r) begin
      fw_addr = blk_r;
      fw_hdr  = hba_pkg::mk_hdr(1'b1, blk_h_r.size + hn_r.size
                                + hba_pkg::SIZE_W'(hba_pkg::HEADER_BYTES), hn_r.next);
    end else begin
      fw_addr = blk_r;
      fw_hdr  = hba_pkg::mk_hdr(1'b1, blk_h_r.size, blk_h_r.next);
    end
  end

  // Next state and working registers.
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    req_nxt        = req_r;
    ptr_nxt        = ptr_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    found_nxt      = found_r;
    best_nxt       = best_r;
    best_h_nxt     = best_h_r;
    mindiff_nxt    = mindiff_r;
    prev_nxt       = prev_r;
    prev_h_nxt     = prev_h_r;
    blk_nxt        = blk_r;
    blk_h_nxt      = blk_h_r;
    hn_nxt         = hn_r;
    nf_nxt         = nf_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    case (state_r)
      hba_pkg::S_INIT: begin
        state_nxt = hba_pkg::S_IDLE;
      end
      hba_pkg::S_IDLE: begin
        if (in_acc) begin
          kind_nxt       = in_kind;
          req_nxt        = in_alloc_size;
          ptr_nxt        = in_block_offset;
          cur_nxt        = hba_pkg::ANCHOR_ADDR;
          steps_nxt      = '0;
          found_nxt      = 1'b0;
          prev_nxt       = '0;
          res_off_nxt    = '0;
          res_status_nxt = (in_kind == hba_pkg::KIND_UNUSED) ? hba_pkg::STAT_UNKNOWN
                                                             : hba_pkg::STAT_FAIL;
          state_nxt      = need_walk ? hba_pkg::S_WALK : hba_pkg::S_DONE;
        end
      end
      hba_pkg::S_WALK: begin
        steps_nxt = steps_r + hba_pkg::ADDR_W'(1);
        cur_nxt   = rd_data.next;
        if (kind_r == hba_pkg::KIND_ALLOC) begin
          if (take) begin
            found_nxt   = 1'b1;
            best_nxt    = cur_r;
            best_h_nxt  = rd_data;
            mindiff_nxt = diff;
          end
          if (h_last) begin
            state_nxt = (found_r || take) ? hba_pkg::S_AFIN : hba_pkg::S_DONE;
          end
        end else if (match) begin
          if (kind_r == hba_pkg::KIND_CHECK) begin
            res_status_nxt = rd_data.is_free ? hba_pkg::STAT_FAIL : hba_pkg::STAT_OK;
            state_nxt      = hba_pkg::S_DONE;
          end else if (rd_data.is_free) begin
            res_status_nxt = hba_pkg::STAT_DFREE;
            state_nxt      = hba_pkg::S_DONE;
          end else begin
            blk_nxt   = cur_r;
            blk_h_nxt = rd_data;
            nf_nxt    = 1'b0;
            state_nxt = (rd_data.next != '0) ? hba_pkg::S_FNEXT : hba_pkg::S_FWRITE;
          end
        end else begin
          prev_nxt   = cur_r;
          prev_h_nxt = rd_data;
          if (h_last) begin
            res_status_nxt = (kind_r == hba_pkg::KIND_FREE) ? hba_pkg::STAT_UNKNOWN
                                                           : hba_pkg::STAT_FAIL;
            state_nxt      = hba_pkg::S_DONE;
          end
        end
      end
      hba_pkg::S_AFIN: begin
        res_status_nxt = hba_pkg::STAT_OK;
        res_off_nxt    = best_r + hba_pkg::ADDR_W'(hba_pkg::HEADER_BYTES);
        state_nxt      = split ? hba_pkg::S_AWRITE : hba_pkg::S_DONE;
      end
      hba_pkg::S_AWRITE: begin
        state_nxt = hba_pkg::S_DONE;
      end
      hba_pkg::S_FNEXT: begin
        hn_nxt    = rd_data;
        nf_nxt    = rd_data.is_free;
        state_nxt = hba_pkg::S_FWRITE;
      end
      hba_pkg::S_FWRITE: begin
        res_status_nxt = hba_pkg::STAT_OK;
        state_nxt      = hba_pkg::S_DONE;
      end
      hba_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_off_nxt    = res_off_r;
          state_nxt      = hba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = hba_pkg::S_IDLE;
      end
    endcase
  end

  // Handshakes and memory accesses.
  always_comb begin
    in_stall        = (state_r != hba_pkg::S_IDLE);
    cfg_ready       = (state_r == hba_pkg::S_IDLE) && !in_valid;
    mem_req.rd_en   = 1'b0;
    mem_req.rd_addr = hba_pkg::ANCHOR_ADDR;
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = hba_pkg::ANCHOR_ADDR;
    mem_req.wr_data = hba_pkg::region_hdr(hba_pkg::SIZE_MAX);
    case (state_r)
      hba_pkg::S_INIT: begin
        mem_req.wr_en = 1'b1;
      end
      hba_pkg::S_IDLE: begin
        if (cfg_acc) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_data = hba_pkg::region_hdr(cfg_region_size);
        end
        mem_req.rd_en = in_acc && need_walk;
      end
      hba_pkg::S_WALK: begin
        mem_req.rd_addr = rd_data.next;
        if (kind_r == hba_pkg::KIND_ALLOC) begin
          mem_req.rd_en = !h_last;
        end else if (match) begin
          mem_req.rd_en = (kind_r == hba_pkg::KIND_FREE) && !rd_data.is_free
                          && (rd_data.next != '0);
        end else begin
          mem_req.rd_en = !h_last;
        end
      end
      hba_pkg::S_AFIN: begin
        mem_req.wr_en = 1'b1;
        if (split) begin
          mem_req.wr_addr = nb_addr;
          mem_req.wr_data = hba_pkg::mk_hdr(1'b1, best_h_r.size
                            - hba_pkg::SIZE_W'(hba_pkg::HEADER_BYTES) - req_r, best_h_r.next);
        end else begin
          mem_req.wr_addr = best_r;
          mem_req.wr_data = hba_pkg::mk_hdr(1'b0, best_h_r.size, best_h_r.next);
        end
      end
      hba_pkg::S_AWRITE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = best_r;
        mem_req.wr_data = hba_pkg::mk_hdr(1'b0, req_r, nb_addr);
      end
      hba_pkg::S_FWRITE: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = fw_addr;
        mem_req.wr_data = fw_hdr;
      end
      default: begin
      end
    endcase
    out_valid       = out_valid_r;
    out_status      = out_status_r;
    out_user_offset = out_off_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hba_pkg::S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    req_r        <= req_nxt;
    ptr_r        <= ptr_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_h_r     <= best_h_nxt;
    mindiff_r    <= mindiff_nxt;
    prev_r       <= prev_nxt;
    prev_h_r     <= prev_h_nxt;
    blk_r        <= blk_nxt;
    blk_h_r      <= blk_h_nxt;
    hn_r         <= hn_nxt;
    nf_r         <= nf_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
  end

endmodule

### test/tb.sv
// Self-checking testbench of the best-fit heap allocator with its own heap predictor.
module tb;

  localparam int CYCLE_LIMIT = 3000000;

  // One request together with the result predicted for it.
  typedef struct {
    logic [1:0]                 kind;
    logic [hba_pkg::SIZE_W-1:0] req_size;
    logic [hba_pkg::ADDR_W-1:0] ptr;
    logic [1:0]                 exp_status;
    logic [hba_pkg::ADDR_W-1:0] exp_offset;
  } request_t;

  typedef struct {
    logic [1:0]                 status;
    logic [hba_pkg::ADDR_W-1:0] offset;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = hba_pkg::KIND_ALLOC;
  logic [hba_pkg::SIZE_W-1:0] in_alloc_size = '0;
  logic [hba_pkg::ADDR_W-1:0] in_block_offset = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [hba_pkg::SIZE_W-1:0] cfg_region_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [hba_pkg::ADDR_W-1:0] out_user_offset;

  request_t pending_reqs[$];
  answer_t  due_answers[$];
  int error_count = 0;
  int cycle_count = 0;

  // Shadow heap: headers by byte offset and the saturated region size.
  logic [25:0] heap_hdr [0:hba_pkg::REGION_BYTES-1];
  int heap_bytes;
  int live_ptrs[$];

  best_fit_heap_allocator dut (.*);

  // Clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rebuilds the shadow heap for a written region size.
  task automatic set_region(input int v);
    if (v < hba_pkg::ANCHOR_BYTES + hba_pkg::HEADER_BYTES + 1)
      v = hba_pkg::ANCHOR_BYTES + hba_pkg::HEADER_BYTES + 1;
    if (v > hba_pkg::REGION_BYTES) v = hba_pkg::REGION_BYTES;
    heap_bytes = v;
    heap_hdr[hba_pkg::ANCHOR_BYTES] =
      {1'b1, 13'(v - hba_pkg::ANCHOR_BYTES - hba_pkg::HEADER_BYTES), 12'd0};
    live_ptrs.delete();
  endtask

  function automatic logic [25:0] mk(input int f, input int s, input int n);
    return {1'(f), 13'(s), 12'(n)};
  endfunction

  // Finds the block whose payload starts at ptr.
  task automatic find_block(input int ptr, output bit hit, output int blk, output int prev);
    int cur, p, steps;
    cur = hba_pkg::ANCHOR_BYTES;
    p = 0;
    steps = 0;
    hit = 0;
    blk = 0;
    prev = 0;
    while (cur != 0 && steps < hba_pkg::REGION_BYTES && !hit) begin
      if (cur + hba_pkg::HEADER_BYTES == ptr) begin
        hit = 1;
        blk = cur;
        prev = p;
      end else begin
        p = cur;
        cur = heap_hdr[cur][11:0];
        steps++;
      end
    end
  endtask

  // Applies one request to the shadow heap and returns its result.
  task automatic heap_apply(input logic [1:0] kind, input int req, input int ptr,
                            output logic [1:0] st, output logic [hba_pkg::ADDR_W-1:0] uo);
    int cur, best, mindiff, steps, sz, nb, nx, blk, prev, hs, ps, ns;
    bit found, hit, pf, nf;
    logic [25:0] h, hp, hn;
    st = hba_pkg::STAT_FAIL;
    uo = '0;
    case (kind)
      hba_pkg::KIND_ALLOC: begin
        if (req != 0) begin
          cur = hba_pkg::ANCHOR_BYTES;
          found = 0;
          best = 0;
          mindiff = 0;
          steps = 0;
          while (cur != 0 && steps < hba_pkg::REGION_BYTES) begin
            h = heap_hdr[cur];
            if (h[25] && int'(h[24:12]) >= req) begin
              if (!found || int'(h[24:12]) - req <= mindiff) begin
                mindiff = int'(h[24:12]) - req;
                best = cur;
                found = 1;
              end
            end
            cur = h[11:0];
            steps++;
          end
          if (found) begin
            h = heap_hdr[best];
            sz = h[24:12];
            if (sz >= req + hba_pkg::HEADER_BYTES) begin
              nb = best + hba_pkg::HEADER_BYTES + req;
              if (nb < hba_pkg::REGION_BYTES)
                heap_hdr[nb] = mk(1, sz - hba_pkg::HEADER_BYTES - req, h[11:0]);
              heap_hdr[best] = mk(0, req, nb);
            end else begin
              heap_hdr[best] = mk(0, sz, h[11:0]);
            end
            st = hba_pkg::STAT_OK;
            uo = 12'(best + hba_pkg::HEADER_BYTES);
          end
        end
      end
      hba_pkg::KIND_FREE: begin
        find_block(ptr, hit, blk, prev);
        if (!hit) begin
          st = hba_pkg::STAT_UNKNOWN;
        end else if (heap_hdr[blk][25]) begin
          st = hba_pkg::STAT_DFREE;
        end else begin
          h = heap_hdr[blk];
          nx = h[11:0];
          hp = heap_hdr[prev];
          hn = heap_hdr[nx];
          pf = prev != 0 && hp[25];
          nf = nx != 0 && hn[25];
          hs = h[24:12];
          ps = hp[24:12];
          ns = hn[24:12];
          if (pf && nf)
            heap_hdr[prev] = mk(1, ps + hs + ns + 2 * hba_pkg::HEADER_BYTES, hn[11:0]);
          else if (pf) heap_hdr[prev] = mk(1, ps + hs + hba_pkg::HEADER_BYTES, nx);
          else if (nf) heap_hdr[blk] = mk(1, hs + ns + hba_pkg::HEADER_BYTES, hn[11:0]);
          else heap_hdr[blk] = mk(1, hs, nx);
          st = hba_pkg::STAT_OK;
        end
      end
      hba_pkg::KIND_CHECK: begin
        find_block(ptr, hit, blk, prev);
        st = (hit && !heap_hdr[blk][25]) ? hba_pkg::STAT_OK : hba_pkg::STAT_FAIL;
      end
      default: st = hba_pkg::STAT_UNKNOWN;
    endcase
  endtask

  // Predicts a request, records live pointers and queues it for the driver.
  task automatic queue_req(input logic [1:0] kind, input int req, input int ptr);
    request_t r;
    r.kind = kind;
    r.req_size = 13'(req);
    r.ptr = 12'(ptr);
    heap_apply(kind, req, ptr, r.exp_status, r.exp_offset);
    if (kind == hba_pkg::KIND_ALLOC && r.exp_status == hba_pkg::STAT_OK)
      live_ptrs.push_back(r.exp_offset);
    pending_reqs.push_back(r);
  endtask

  // Frees or checks a random live pointer, or a random offset now and then.
  task automatic queue_free_or_check(input logic [1:0] kind);
    int idx, p;
    if (live_ptrs.size() > 0 && $urandom_range(0, 9) < 8) begin
      idx = $urandom_range(0, live_ptrs.size() - 1);
      p = live_ptrs[idx];
      if (kind == hba_pkg::KIND_FREE) live_ptrs.delete(idx);
    end else begin
      p = $urandom_range(0, 4095);
    end
    queue_req(kind, 0, p);
  endtask

  // Waits until every request has been answered and the block has settled.
  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || due_answers.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the region size and rebuilds the shadow heap.
  task automatic write_region(input int v);
    cfg_region_size <= 13'(v);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    set_region(v);
  endtask

  task automatic random_items(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        if ($urandom_range(0, 19) == 0)
          queue_req(hba_pkg::KIND_ALLOC, 0, $urandom_range(0, 4095));
        else if ($urandom_range(0, 19) == 0)
          queue_req(hba_pkg::KIND_ALLOC, $urandom_range(0, 4096), $urandom_range(0, 4095));
        else queue_req(hba_pkg::KIND_ALLOC, $urandom_range(1, 64), $urandom_range(0, 4095));
      end else if (pick < 80) begin
        queue_free_or_check(hba_pkg::KIND_FREE);
      end else if (pick < 96) begin
        queue_free_or_check(hba_pkg::KIND_CHECK);
      end else begin
        queue_req(hba_pkg::KIND_UNUSED, $urandom_range(0, 4096), $urandom_range(0, 4095));
      end
    end
  endtask

  // Stimulus: directed items, then random phases under several region sizes.
  initial begin
    int sizes[7] = '{14, 13, 0, 8191, 200, 4096, 1000};
    set_region(hba_pkg::REGION_BYTES);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    queue_req(hba_pkg::KIND_ALLOC, 0, 0);
    queue_req(hba_pkg::KIND_ALLOC, 4096, 0);
    queue_req(hba_pkg::KIND_ALLOC, 4083, 0);
    queue_req(hba_pkg::KIND_CHECK, 0, 13);
    queue_req(hba_pkg::KIND_FREE, 0, 13);
    queue_req(hba_pkg::KIND_FREE, 0, 13);
    queue_req(hba_pkg::KIND_CHECK, 0, 13);
    queue_req(hba_pkg::KIND_FREE, 0, 5);
    queue_req(hba_pkg::KIND_CHECK, 0, 4095);
    queue_req(hba_pkg::KIND_UNUSED, 4096, 4095);
    queue_req(hba_pkg::KIND_ALLOC, 10, 0);
    queue_req(hba_pkg::KIND_ALLOC, 20, 0);
    queue_req(hba_pkg::KIND_ALLOC, 10, 0);
    queue_req(hba_pkg::KIND_FREE, 0, 13);
    queue_req(hba_pkg::KIND_FREE, 0, 32);
    queue_req(hba_pkg::KIND_ALLOC, 1, 0);
    queue_req(hba_pkg::KIND_FREE, 0, 61);
    queue_req(hba_pkg::KIND_FREE, 0, 13);
    live_ptrs.delete();
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) write_region(ph == 7 ? $urandom_range(0, 8191) : sizes[ph - 1]);
      random_items(ph == 0 ? 250 : 85);
      drain();
    end
    drain();
    repeat (50) @(posedge clk);
    if (error_count == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  // Driver: sends queued requests in bursts with random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    bit free_slot;
    request_t r;
    free_slot = !in_valid;
    if (in_valid && !in_stall) begin
      due_answers.push_back('{status: pending_reqs[0].exp_status,
                              offset: pending_reqs[0].exp_offset});
      void'(pending_reqs.pop_front());
      free_slot = 1;
    end
    if (free_slot && rst_n) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs[0];
        in_valid <= 1'b1;
        in_kind <= r.kind;
        in_alloc_size <= r.req_size;
        in_block_offset <= r.ptr;
        burst_left--;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result item with the oldest expectation.
  int stall_mode = 0;
  always @(posedge clk) begin
    answer_t a;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
    if (out_valid && !out_stall) begin
      if (due_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d offset %0d",
                 $time, out_status, out_user_offset);
        error_count++;
      end else begin
        a = due_answers.pop_front();
        if (out_status !== a.status) begin
          $display("%0t: status expected %0d actual %0d", $time, a.status, out_status);
          error_count++;
        end
        if (out_user_offset !== a.offset) begin
          $display("%0t: user_offset expected %0d actual %0d", $time, a.offset,
                   out_user_offset);
          error_count++;
        end
      end
    end
    // The receiver changes its stall pattern at regular intervals.
    if (cycle_count % 64 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // Leftover expectations are failures.
  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      if (due_answers.size() > 0) error_count++;
    end
  end

endmodule

### files.f
rtl/hba_pkg.sv
rtl/hba_mem.sv
rtl/hba_ctrl.sv
rtl/best_fit_heap_allocator.sv
test/tb.sv
